// ===== rtl/led_pixel_blend_compositor_defines.svh =====
// assertion macros shared by the compositor rtl
`ifndef LED_PIXEL_BLEND_COMPOSITOR_DEFINES_SVH
`define LED_PIXEL_BLEND_COMPOSITOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define LBC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lbc assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define LBC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lbc assertion failed");

`endif

// ===== rtl/lbc_pkg.sv =====
// types, constants and helpers shared by the compositor modules
package lbc_pkg;

	localparam int unsigned CH_W     = 8;
	localparam int unsigned NUM_CH   = 3;
	localparam int unsigned COLOR_W  = CH_W * NUM_CH;
	localparam int unsigned SUM_W    = 10;
	localparam int unsigned NUM_W    = 18;
	localparam int unsigned THIRD_W  = 16;
	localparam int unsigned RECIP_W  = 19;
	localparam int unsigned RECIP_SH = 20;

	// channel sum ceiling, three full channels
	localparam logic [SUM_W-1:0] SUM_MAX = 10'd765;
	// ceil(2^20 / 3), exact floor(n/3) for n below 2^19
	localparam logic [RECIP_W-1:0] RECIP3 = 19'd349526;

	typedef enum logic [1:0] {
		BLEND_NONE,
		BLEND_INVERT,
		BLEND_THRESH,
		BLEND_LERP
	} blend_mode_t;

	typedef enum logic [2:0] {
		CMB_MAX,
		CMB_MIN,
		CMB_AVG,
		CMB_MUL,
		CMB_ADD,
		CMB_SUB,
		CMB_REPLACE
	} combine_mode_t;

	typedef enum logic [1:0] {
		REG_BLEND,
		REG_COMBINE,
		REG_PRIMARY,
		REG_SECONDARY
	} cfg_reg_t;

	typedef struct packed {
		blend_mode_t         blend;
		combine_mode_t       combine;
		logic [COLOR_W-1:0]  primary;
		logic [COLOR_W-1:0]  secondary;
	} lbc_cfg_t;

	typedef struct packed {
		logic                valid;
		logic [COLOR_W-1:0]  target;
		logic [COLOR_W-1:0]  shaped;
	} lbc_shaped_t;

	// exact floor(x/255) for x up to 255*255
	function automatic logic [CH_W-1:0] div255(input logic [2*CH_W-1:0] x);
		logic [2*CH_W:0] t;
		t = {1'b0, x} + 17'd1 + {9'd0, x[2*CH_W-1:CH_W]};
		return t[2*CH_W-1:CH_W];
	endfunction

endpackage

// ===== rtl/led_pixel_blend_compositor.sv =====
// top level of the led pixel blend compositor
// Streams one pixel per transfer: target_color and source_color enter on the
// input channel (in_valid / in_stall), result_color leaves on the output
// channel (out_valid / out_stall). Colours pack red in bits 7:0, green in
// 15:8 and blue in 23:16.
// Configuration goes through the write port (cfg_wr_en, cfg_index, cfg_data)
// and must be changed only while no pixel is in flight; the block does not enforce this.
// The result passes through five register stages: channel sum, lerp products,
// divide by 3, divide by 255 with source select, combine.
// Throughput is one pixel per cycle while out_stall is low; each stage holds one
// pixel and moves whenever the stage after it is empty or moving.
// When the receiver stalls, the result holds in the output register and
// upstream stages keep filling their empty slots; in_stall rises only once
// all five stages hold a pixel.
// Reset empties the pipeline and loads blend mode lerp, combine mode replace
// and black primary and secondary colours.
`include "led_pixel_blend_compositor_defines.svh"

module led_pixel_blend_compositor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [23:0] target_color,
	input  logic [23:0] source_color,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [23:0] result_color
);
	import lbc_pkg::*;

	lbc_cfg_t    cfg;
	lbc_shaped_t shaped;
	logic        comb_ready;

	// configuration registers
	lbc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// source shaping pipeline
	lbc_shape u_shape (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.target_color (target_color),
		.source_color (source_color),
		.dn_ready     (comb_ready),
		.shaped       (shaped)
	);

	// combine and output register
	lbc_combine u_combine (
		.clk          (clk),
		.arst_n       (arst_n),
		.combine      (cfg.combine),
		.shaped       (shaped),
		.up_ready     (comb_ready),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_color (result_color)
	);

	// input blocks only behind a stalled result
	`LBC_ASSERT_SAME(a_stall_source, in_stall, out_valid && out_stall)
	// threshold mode only yields black or one of the two colours
	`LBC_ASSERT_SAME(a_thresh_pick, shaped.valid && cfg.blend == BLEND_THRESH,
		shaped.shaped == '0 || shaped.shaped == cfg.primary || shaped.shaped == cfg.secondary)
	// a shaped pixel taken by the combine stage shows up as a result
	`LBC_ASSERT_NEXT(a_combine_fill, shaped.valid && comb_ready, out_valid)

endmodule

// ===== rtl/lbc_cfg_regs.sv =====
// configuration register file for the compositor
module lbc_cfg_regs (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [1:0]            cfg_index,
	input  logic [23:0]           cfg_data,
	output lbc_pkg::lbc_cfg_t     cfg
);
	import lbc_pkg::*;

	lbc_cfg_t cfg_q;

	// register writes by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blend     <= BLEND_LERP;
			cfg_q.combine   <= CMB_REPLACE;
			cfg_q.primary   <= '0;
			cfg_q.secondary <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_BLEND:     cfg_q.blend     <= blend_mode_t'(cfg_data[1:0]);
				REG_COMBINE:   cfg_q.combine   <= combine_mode_t'(cfg_data[2:0]);
				REG_PRIMARY:   cfg_q.primary   <= cfg_data[COLOR_W-1:0];
				REG_SECONDARY: cfg_q.secondary <= cfg_data[COLOR_W-1:0];
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/lbc_shape.sv =====
// four-stage source shaping pipeline: sum, lerp products, divide by 3, divide by 255
module lbc_shape (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lbc_pkg::lbc_cfg_t       cfg,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [23:0]             target_color,
	input  logic [23:0]             source_color,
	input  logic                    dn_ready,
	output lbc_pkg::lbc_shaped_t    shaped
);
	import lbc_pkg::*;

	// stage enables, each stage moves when empty or when the next one moves
	logic en1, en2, en3, en4;
	logic v_s1, v_s2, v_s3, v_s4;

	assign en4 = !v_s4 || dn_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// stage 1: channel sum of the source
	logic [COLOR_W-1:0] target_s1, source_s1;
	logic [SUM_W-1:0]   sum_s1;
	logic [SUM_W-1:0]   sum_d1;

	assign sum_d1 = {2'b00, source_color[7:0]} + {2'b00, source_color[15:8]}
		+ {2'b00, source_color[23:16]};

	always_ff @(posedge clk) begin
		if (en1) begin
			target_s1 <= target_color;
			source_s1 <= source_color;
			sum_s1    <= sum_d1;
		end
	end

	// stage 2: non-lerp modes and lerp numerators per channel
	logic [COLOR_W-1:0] target_s2, simple_s2, simple_d2;
	logic               nz_s2;
	logic [NUM_W-1:0]   num_s2 [NUM_CH];
	logic [NUM_W-1:0]   num_d2 [NUM_CH];
	logic [SUM_W-1:0]   rest_d2;

	assign rest_d2 = SUM_MAX - sum_s1;

	always_comb begin
		case (cfg.blend)
			BLEND_NONE:   simple_d2 = source_s1;
			BLEND_INVERT: simple_d2 = (|source_s1) ? ~source_s1 : '0;
			BLEND_THRESH: begin
				if (sum_s1 == '0)
					simple_d2 = '0;
				else if ({sum_s1, 1'b0} < {1'b0, SUM_MAX})
					simple_d2 = cfg.primary;
				else
					simple_d2 = cfg.secondary;
			end
			default:      simple_d2 = '0;
		endcase
	end

	always_comb begin
		for (int k = 0; k < NUM_CH; k++) begin
			num_d2[k] = cfg.primary[k*CH_W +: CH_W] * rest_d2
				+ cfg.secondary[k*CH_W +: CH_W] * sum_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			target_s2 <= target_s1;
			simple_s2 <= simple_d2;
			nz_s2     <= |source_s1;
			num_s2    <= num_d2;
		end
	end

	// stage 3: divide numerators by 3 through the reciprocal
	logic [COLOR_W-1:0]     target_s3, simple_s3;
	logic                   nz_s3;
	logic [THIRD_W-1:0]     third_s3 [NUM_CH];
	logic [THIRD_W-1:0]     third_d3 [NUM_CH];
	logic [NUM_W+RECIP_W-1:0] prod_d3 [NUM_CH];

	always_comb begin
		for (int k = 0; k < NUM_CH; k++) begin
			prod_d3[k]  = num_s2[k] * RECIP3;
			third_d3[k] = prod_d3[k][RECIP_SH +: THIRD_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			target_s3 <= target_s2;
			simple_s3 <= simple_s2;
			nz_s3     <= nz_s2;
			third_s3  <= third_d3;
		end
	end

	// stage 4: divide by 255 and pick the shaped source
	logic [COLOR_W-1:0] target_s4, shaped_s4, lerp_d4, shaped_d4;

	always_comb begin
		for (int k = 0; k < NUM_CH; k++) begin
			lerp_d4[k*CH_W +: CH_W] = div255(third_s3[k]);
		end
	end

	assign shaped_d4 = (cfg.blend == BLEND_LERP) ? (nz_s3 ? lerp_d4 : '0) : simple_s3;

	always_ff @(posedge clk) begin
		if (en4) begin
			target_s4 <= target_s3;
			shaped_s4 <= shaped_d4;
		end
	end

	assign shaped.valid  = v_s4;
	assign shaped.target = target_s4;
	assign shaped.shaped = shaped_s4;

endmodule

// ===== rtl/lbc_combine.sv =====
// combine stage: merges the shaped source with the target and holds the result
module lbc_combine (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lbc_pkg::combine_mode_t  combine,
	input  lbc_pkg::lbc_shaped_t    shaped,
	output logic                    up_ready,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [23:0]             result_color
);
	import lbc_pkg::*;

	logic               valid_s5;
	logic [COLOR_W-1:0] result_s5;
	logic [COLOR_W-1:0] result_d5;
	logic               en5;

	assign en5      = !valid_s5 || !out_stall;
	assign up_ready = en5;

	// per channel merge, replace acts on the whole word
	always_comb begin
		logic [CH_W-1:0]   a, b;
		logic [CH_W:0]     s;
		logic [2*CH_W-1:0] p;
		result_d5 = '0;
		for (int k = 0; k < NUM_CH; k++) begin
			a = shaped.target[k*CH_W +: CH_W];
			b = shaped.shaped[k*CH_W +: CH_W];
			s = {1'b0, a} + {1'b0, b};
			p = a * b;
			case (combine)
				CMB_MAX: result_d5[k*CH_W +: CH_W] = (a > b) ? a : b;
				CMB_MIN: result_d5[k*CH_W +: CH_W] = (a < b) ? a : b;
				CMB_AVG: result_d5[k*CH_W +: CH_W] = s[CH_W:1];
				CMB_MUL: result_d5[k*CH_W +: CH_W] = div255(p);
				CMB_ADD: result_d5[k*CH_W +: CH_W] = s[CH_W] ? '1 : s[CH_W-1:0];
				CMB_SUB: result_d5[k*CH_W +: CH_W] = (a > b) ? (a - b) : '0;
				default: result_d5[k*CH_W +: CH_W] = (|shaped.shaped)
					? b : a;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en5) begin
			valid_s5 <= shaped.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			result_s5 <= result_d5;
		end
	end

	assign out_valid    = valid_s5;
	assign result_color = result_s5;

endmodule

// ===== test/tb_led_pixel_blend_compositor.sv =====
// self-checking testbench for the led pixel blend compositor
`timescale 1ns / 100ps

module tb_led_pixel_blend_compositor;
	import lbc_pkg::*;

	localparam int unsigned PIPE_LAT    = 8;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned LONG_HOLD   = 40;
	localparam int unsigned NUM_SEG     = 32;
	localparam int unsigned SEG_ITEMS   = 32;
	localparam int unsigned CH_FULL     = 255;
	localparam logic [2:0]  CMB_UNUSED  = 3'd7;

	typedef struct packed {
		logic [COLOR_W-1:0] target;
		logic [COLOR_W-1:0] source;
	} pixel_pair_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               cfg_wr_en    = 1'b0;
	logic [1:0]         cfg_index    = REG_BLEND;
	logic [23:0]        cfg_data     = '0;
	logic               in_valid     = 1'b0;
	logic               in_stall;
	logic [23:0]        target_color = '0;
	logic [23:0]        source_color = '0;
	logic               out_valid;
	logic               out_stall    = 1'b0;
	logic [23:0]        result_color;

	// mirrored configuration, reset values of the block
	blend_mode_t        blend_sel    = BLEND_LERP;
	logic [2:0]         combine_sel  = CMB_REPLACE;
	logic [COLOR_W-1:0] prim_rgb     = '0;
	logic [COLOR_W-1:0] sec_rgb      = '0;

	pixel_pair_t        pixel_feed[$];
	logic [COLOR_W-1:0] expected_rgb[$];
	pixel_pair_t        feed_item;
	logic [COLOR_W-1:0] want_rgb;
	int unsigned        tx_idle_pct  = 0;
	int unsigned        rx_idle_pct  = 0;
	int unsigned        hold_cnt     = 0;
	bit                 rx_block_req = 1'b0;
	int unsigned        mismatch_cnt = 0;
	int unsigned        cycle_cnt    = 0;

	led_pixel_blend_compositor u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.target_color (target_color),
		.source_color (source_color),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_color (result_color)
	);

	always #6 clk = ~clk;

	// source stage: reshape the frame colour
	function automatic logic [COLOR_W-1:0] shape_source(logic [COLOR_W-1:0] src);
		int unsigned s, p, q, v;
		logic [COLOR_W-1:0] res;
		s = src[7:0];
		s += src[15:8];
		s += src[23:16];
		res = '0;
		case (blend_sel)
			BLEND_NONE: res = src;
			BLEND_INVERT: res = (src != '0) ? ~src : '0;
			BLEND_THRESH: begin
				if (s != 0)
					res = (2 * s < SUM_MAX) ? prim_rgb : sec_rgb;
			end
			default: begin
				if (src != '0) begin
					for (int k = 0; k < NUM_CH; k++) begin
						p = prim_rgb[CH_W*k +: CH_W];
						q = sec_rgb[CH_W*k +: CH_W];
						v = (p * (SUM_MAX - s) + q * s) / SUM_MAX;
						res[CH_W*k +: CH_W] = v[CH_W-1:0];
					end
				end
			end
		endcase
		return res;
	endfunction

	// combine stage: merge the shaped source into the target per channel
	function automatic logic [COLOR_W-1:0] composite_pixel(logic [COLOR_W-1:0] tgt,
			logic [COLOR_W-1:0] src);
		logic [COLOR_W-1:0] c, res;
		int unsigned a, b, v;
		c = shape_source(src);
		res = '0;
		for (int k = 0; k < NUM_CH; k++) begin
			a = tgt[CH_W*k +: CH_W];
			b = c[CH_W*k +: CH_W];
			case (combine_sel)
				CMB_MAX: v = (a > b) ? a : b;
				CMB_MIN: v = (a < b) ? a : b;
				CMB_AVG: v = (a + b) / 2;
				CMB_MUL: v = (a * b) / CH_FULL;
				CMB_ADD: v = (a + b > CH_FULL) ? CH_FULL : a + b;
				CMB_SUB: v = (a > b) ? a - b : 0;
				default: v = 0;
			endcase
			res[CH_W*k +: CH_W] = v[CH_W-1:0];
		end
		// replace, and the unused code acting as replace
		if (combine_sel >= CMB_REPLACE)
			res = (c != '0) ? c : tgt;
		return res;
	endfunction

	// colour whose channel sum is exactly sum
	function automatic logic [COLOR_W-1:0] color_with_sum(int unsigned sum);
		int unsigned r, g, rem;
		r = $urandom_range(sum > 2 * CH_FULL ? sum - 2 * CH_FULL : 0,
			sum > CH_FULL ? CH_FULL : sum);
		rem = sum - r;
		g = $urandom_range(rem > CH_FULL ? rem - CH_FULL : 0, rem > CH_FULL ? CH_FULL : rem);
		return {8'(rem - g), 8'(g), 8'(r)};
	endfunction

	// random colour, biased toward black, white and the sum corners
	function automatic logic [COLOR_W-1:0] pick_color(bit for_source);
		logic [COLOR_W-1:0] c;
		c = 24'($urandom_range(0, 24'hFFFFFF));
		case ($urandom_range(0, 11))
			0: c = '0;
			1: c = '1;
			2, 3: if (for_source) c = color_with_sum($urandom_range(380, 385));
			4: if (for_source) c = color_with_sum($urandom_range(1, 3));
			5: for (int k = 0; k < NUM_CH; k++)
				c[CH_W*k +: CH_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			default: ;
		endcase
		return c;
	endfunction

	task automatic queue_pixel(logic [COLOR_W-1:0] tgt, logic [COLOR_W-1:0] src);
		pixel_pair_t p;
		p.target = tgt;
		p.source = src;
		pixel_feed.push_back(p);
	endtask

	// sender pauses until every result is back, then the pipe settles
	task automatic drain_pipeline();
		while (pixel_feed.size() != 0 || in_valid || expected_rgb.size() != 0)
			@(negedge clk);
		repeat (PIPE_LAT) @(negedge clk);
	endtask

	// write all four registers while the block is idle
	task automatic set_config(blend_mode_t b, logic [2:0] c, logic [23:0] p, logic [23:0] q);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_COMBINE;
		cfg_data  <= {21'd0, c};
		@(posedge clk);
		cfg_index <= REG_BLEND;
		cfg_data  <= {22'd0, b};
		@(posedge clk);
		cfg_index <= REG_SECONDARY;
		cfg_data  <= q;
		@(posedge clk);
		cfg_index <= REG_PRIMARY;
		cfg_data  <= p;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		blend_sel   = b;
		combine_sel = c;
		prim_rgb    = p;
		sec_rgb     = q;
		@(negedge clk);
	endtask

	// input driver, predicts each transfer as it is accepted
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				expected_rgb.push_back(composite_pixel(target_color, source_color));
			if (!in_valid || !in_stall) begin
				if (pixel_feed.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
					feed_item = pixel_feed.pop_front();
					in_valid     <= 1'b1;
					target_color <= feed_item.target;
					source_color <= feed_item.source;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall, random or one long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_cnt != 0) begin
			out_stall <= 1'b1;
			hold_cnt  <= hold_cnt - 1;
		end else if (rx_block_req) begin
			out_stall    <= 1'b1;
			hold_cnt     <= LONG_HOLD;
			rx_block_req <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	// output monitor, compares each result transfer with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_rgb.size() == 0) begin
				mismatch_cnt++;
				$display("%0t: result_color unexpected, expected none, actual %06h",
					$time, result_color);
			end else begin
				want_rgb = expected_rgb.pop_front();
				if (result_color !== want_rgb) begin
					mismatch_cnt++;
					$display("%0t: result_color mismatch, expected %06h, actual %06h",
						$time, want_rgb, result_color);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset configuration: lerp between black colours, replace
		queue_pixel(24'hFFFFFF, 24'h000000);
		queue_pixel(24'h000000, 24'hFFFFFF);
		queue_pixel(24'h123456, 24'h654321);
		drain_pipeline();

		// lerp across the full range, threshold sum edges
		set_config(BLEND_LERP, CMB_REPLACE, 24'h000000, 24'hFFFFFF);
		queue_pixel(24'hFFFFFF, 24'h000001);
		queue_pixel(24'hFFFFFF, 24'h0000FF);
		queue_pixel(24'hFFFFFF, 24'h00FF7F);
		queue_pixel(24'hFFFFFF, 24'h00FF80);
		queue_pixel(24'h000000, 24'hFFFFFF);
		queue_pixel(24'hABCDEF, 24'h000000);
		drain_pipeline();

		// threshold with saturating add
		set_config(BLEND_THRESH, CMB_ADD, 24'hFF8040, 24'h0102FF);
		queue_pixel(24'h808080, 24'h000000);
		queue_pixel(24'h808080, 24'h00FF7F);
		queue_pixel(24'hFFFFFF, 24'h00FF80);
		queue_pixel(24'h000000, 24'hFFFFFF);
		drain_pipeline();

		// invert with saturating subtract
		set_config(BLEND_INVERT, CMB_SUB, 24'hFFFFFF, 24'hFFFFFF);
		queue_pixel(24'hFFFFFF, 24'h000000);
		queue_pixel(24'hFFFFFF, 24'hFFFFFF);
		queue_pixel(24'h808080, 24'h0F0F0F);
		queue_pixel(24'h000000, 24'h123456);
		drain_pipeline();

		// pass through with multiply
		set_config(BLEND_NONE, CMB_MUL, 24'h000000, 24'h000000);
		queue_pixel(24'hFFFFFF, 24'hFFFFFF);
		queue_pixel(24'hFFFFFF, 24'h000001);
		queue_pixel(24'h80FF01, 24'hFEFFFF);
		drain_pipeline();

		// unused combine code behaves as replace
		set_config(BLEND_NONE, CMB_UNUSED, 24'h000000, 24'h000000);
		queue_pixel(24'h123456, 24'h000000);
		queue_pixel(24'h123456, 24'h000100);
		drain_pipeline();

		// random segments: every blend and combine pairing, three idle profiles
		for (int s = 0; s < NUM_SEG; s++) begin
			logic [23:0] p, q;
			case (s % 5)
				0: begin p = 24'h000000; q = 24'hFFFFFF; end
				1: begin p = 24'hFFFFFF; q = 24'h000000; end
				default: begin
					p = 24'($urandom_range(0, 24'hFFFFFF));
					q = 24'($urandom_range(0, 24'hFFFFFF));
				end
			endcase
			set_config(blend_mode_t'(s % 4), 3'(s / 4), p, q);
			case (s * 3 / NUM_SEG)
				0: begin tx_idle_pct = 32; rx_idle_pct = 85; end
				1: begin tx_idle_pct = 85; rx_idle_pct = 32; end
				default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
			endcase
			for (int i = 0; i < SEG_ITEMS; i++)
				queue_pixel(pick_color(1'b0), pick_color(1'b1));
			// long receiver hold-off so the pipeline fills and stalls its input
			if (s == NUM_SEG - 3)
				rx_block_req = 1'b1;
			drain_pipeline();
		end

		if (mismatch_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
